[hdl/vstg_pkg.sv]
// Shared types, constants and state encodings of the triangle generator.
package vstg_pkg;

    // Number of output channels, one lane each
    localparam int CHANNELS = 2;

    // Field widths
    localparam int RATE_W  = 18;
    localparam int IDX_W   = 32;
    localparam int FREQ_W  = 32;
    localparam int PHASE_W = 32;
    localparam int DUTY_W  = 17;
    localparam int LEVEL_W = 16;
    localparam int CNT_W   = 2;
    localparam int TIME_W  = 48;
    localparam int QUOT_W  = 64;
    localparam int U_W     = 32;
    localparam int R_W     = 33;

    // Time divider: quotient bits retired per cycle
    localparam int DIV_STEP  = 8;
    localparam int DIV_CYC   = QUOT_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    // Lane divider: quotient bits of the slope division
    localparam int SQ_W      = 17;
    localparam int SQ_CNT_W  = $clog2(SQ_W);

    // Duty ratio of one in Q1.16
    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'h10000;

    // APB register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_TIME_ORIGIN = 2'd1;
    localparam logic [1:0] REG_CHANNELS    = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET     = 18'd48000;
    localparam logic [CNT_W-1:0]  CHANNELS_RESET = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD,
        ST_MUL,
        ST_PHASE,
        ST_START,
        ST_LANE,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_FIN
    } lane_state_t;

    // Command from the sequencer to every lane
    typedef struct packed {
        logic            start;
        logic [U_W-1:0]  phase;
        logic [R_W-1:0]  ratio;
    } lane_cmd_t;

endpackage

[hdl/vstg_if.sv]
// Stream interfaces for input words and result words.
interface vstg_in_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic [31:0] frequency;
    logic signed [31:0] phase_offset;
    logic [16:0] duty_ratio;
    logic signed [15:0] level_zero;
    logic signed [15:0] level_one;

    modport source (output valid, restart, frequency, phase_offset, duty_ratio,
                    level_zero, level_one, input ready);
    modport sink (input valid, restart, frequency, phase_offset, duty_ratio,
                  level_zero, level_one, output ready);
endinterface

interface vstg_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] sample_zero;
    logic signed [15:0] sample_one;

    modport source (output valid, sample_zero, sample_one, input ready);
    modport sink (input valid, sample_zero, sample_one, output ready);
endinterface

[hdl/vstg_time_div.sv]
// Radix-256 restoring divider: floor(index * 2^32 / rate).
module vstg_time_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vstg_pkg::IDX_W-1:0]    index,
    input  logic [vstg_pkg::RATE_W-1:0]   rate,
    output logic                          done,
    output logic [vstg_pkg::QUOT_W-1:0]   quotient
);
    import vstg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]    work_reg, work_next;
    logic [RATE_W-1:0]    rem_step;
    logic [QUOT_W-1:0]    work_step;

    // Retire eight quotient bits
    always_comb
    begin
        logic [RATE_W:0] trial;
        rem_step  = rem_reg;
        work_step = work_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_step, work_step[QUOT_W-1]};
            if (trial >= {1'b0, rate_reg})
            begin
                rem_step  = RATE_W'(trial - {1'b0, rate_reg});
                work_step = {work_step[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_step  = trial[RATE_W-1:0];
                work_step = {work_step[QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Load on start, iterate while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rate_next = rate_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rate_next = (rate == '0) ? RATE_W'(1) : rate;
            rem_next  = '0;
            work_next = {index, 32'h0};
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            work_next = work_step;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[hdl/vstg_lane.sv]
// One channel lane: slope multiply, bit-serial slope divide, sign and clamp.
module vstg_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vstg_pkg::lane_cmd_t               cmd,
    input  logic signed [vstg_pkg::LEVEL_W-1:0] level,
    output logic                              done,
    output logic signed [vstg_pkg::LEVEL_W-1:0] sample
);
    import vstg_pkg::*;

    lane_state_t            state_reg, state_next;
    logic                   done_next;
    logic                   rising_reg, rising_next;
    logic                   neg_reg, neg_next;
    logic [LEVEL_W-1:0]     mag_reg, mag_next;
    logic [U_W-1:0]         dist_reg, dist_next;
    logic [R_W-1:0]         divisor_reg, divisor_next;
    logic [R_W-1:0]         rem_reg, rem_next;
    logic [SQ_W-1:0]        work_reg, work_next;
    logic [SQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [LEVEL_W-1:0] sample_reg, sample_next;
    logic                   done_reg;
    logic [47:0]            product;
    logic [R_W:0]           trial;
    logic signed [LEVEL_W+2:0] vee;
    logic signed [LEVEL_W+2:0] wye;

    assign product = mag_reg * dist_reg;
    assign trial   = {rem_reg, work_reg[SQ_W-1]};

    // Signed result from the slope quotient held in work_reg
    always_comb
    begin
        if (rising_reg)
            vee = signed'({2'b00, work_reg}) - signed'({3'b000, mag_reg});
        else
            vee = signed'({3'b000, mag_reg}) - signed'({2'b00, work_reg});
        wye = neg_reg ? -vee : vee;
    end

    // Sequence: latch, multiply, divide, finish
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        rising_next  = rising_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        dist_next    = dist_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        sample_next  = sample_reg;
        unique case (state_reg)
            LN_IDLE:
            begin
                if (cmd.start)
                begin
                    rising_next = {1'b0, cmd.phase} < cmd.ratio;
                    neg_next    = level[LEVEL_W-1];
                    mag_next    = level[LEVEL_W-1] ? LEVEL_W'(-level) : level;
                    if ({1'b0, cmd.phase} < cmd.ratio)
                    begin
                        dist_next    = cmd.phase;
                        divisor_next = cmd.ratio;
                    end
                    else
                    begin
                        dist_next    = U_W'({1'b0, cmd.phase} - cmd.ratio);
                        divisor_next = {1'b1, 32'h0} - cmd.ratio;
                    end
                    state_next = LN_MUL;
                end
            end
            LN_MUL:
            begin
                // numerator is 2*m*d; its top bits seed the remainder
                rem_next   = {1'b0, product[47:16]};
                work_next  = {product[15:0], 1'b0};
                cnt_next   = '0;
                state_next = LN_DIV;
            end
            LN_DIV:
            begin
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next  = R_W'(trial - {1'b0, divisor_reg});
                    work_next = {work_reg[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[R_W-1:0];
                    work_next = {work_reg[SQ_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(SQ_W - 1))
                    state_next = LN_FIN;
            end
            LN_FIN:
            begin
                // clamp the one overflow case, a full negative peak
                if (wye > signed'((LEVEL_W+3)'(32767)))
                    sample_next = 16'sh7fff;
                else if (wye < -signed'((LEVEL_W+3)'(32768)))
                    sample_next = 16'sh8000;
                else
                    sample_next = wye[LEVEL_W-1:0];
                done_next  = 1'b1;
                state_next = LN_IDLE;
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rising_reg  <= rising_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        dist_reg    <= dist_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        work_reg    <= work_next;
        sample_reg  <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

[hdl/variable_slope_triangle_generator.sv]
// Top level: register port, sequencer, time and phase datapath, lanes, merge.
//
//  port      dir   handshake      word
//  in_chan   in    valid/ready    restart, frequency, phase_offset, duty_ratio, levels
//  out_chan  out   valid/ready    sample_zero, sample_one
//  apb       in    psel/penable   sample_rate, time_origin, channels_in_use
//
// Each word is taken only while the sequencer is idle and passes in order through
// the radix-256 time divider, time sum, phase multiply and fraction, lane start, the lanes
// (multiply, 17-step slope divide, finish, done) and the output load, then back to idle.
// The next word is taken while a finished result still waits in the output register.
// rst_n clears the registers to their defaults and the sample index to zero.
// A stalled output holds the sequencer only when a second result is ready.
module variable_slope_triangle_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    vstg_in_if.sink                      in_chan,
    vstg_out_if.source                   out_chan,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vstg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import vstg_pkg::*;

    top_state_t                state_reg, state_next;
    logic [RATE_W-1:0]         rate_reg;
    logic [31:0]               origin_reg;
    logic [CNT_W-1:0]          chans_reg;
    logic [IDX_W-1:0]          index_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [R_W-1:0]            ratio_reg;
    logic signed [LEVEL_W-1:0] level_reg [CHANNELS];
    logic [TIME_W-1:0]         time_reg;
    logic [55:0]               prod_lo_reg;
    logic [23:0]               prod_hi_reg;
    logic [U_W-1:0]            u_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [LEVEL_W-1:0] out_zero_reg, out_one_reg;
    logic                      accept;
    logic                      cfg_write;
    logic [IDX_W-1:0]          index_use;
    logic                      div_done;
    logic [QUOT_W-1:0]         quotient;
    logic [TIME_W-1:0]         time_sum;
    logic [TIME_W-1:0]         phase_sum;
    logic [DUTY_W-1:0]         duty_clamped;
    lane_cmd_t                 lane_cmd;
    logic [CHANNELS-1:0]       lane_done;
    logic signed [LEVEL_W-1:0] lane_sample [CHANNELS];
    logic signed [LEVEL_W-1:0] merged [CHANNELS];
    logic                      load_out;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            origin_reg <= '0;
            chans_reg  <= CHANNELS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SAMPLE_RATE: rate_reg   <= pwdata[RATE_W-1:0];
                REG_TIME_ORIGIN: origin_reg <= pwdata;
                REG_CHANNELS:    chans_reg  <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAMPLE_RATE: prdata = {14'h0, rate_reg};
            REG_TIME_ORIGIN: prdata = origin_reg;
            REG_CHANNELS:    prdata = {30'h0, chans_reg};
            default:         prdata = '0;
        endcase
    end

    // Input accept and sample index
    assign in_chan.ready = (state_reg == ST_IDLE);
    assign accept        = in_chan.valid && in_chan.ready;
    assign index_use     = in_chan.restart ? '0 : index_reg;
    assign duty_clamped  = (in_chan.duty_ratio > DUTY_ONE) ? DUTY_ONE : in_chan.duty_ratio;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= '0;
        else if (accept)
            index_reg <= index_use + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            freq_reg     <= in_chan.frequency;
            phase_reg    <= in_chan.phase_offset;
            ratio_reg    <= {duty_clamped, 16'h0};
            level_reg[0] <= in_chan.level_zero;
            level_reg[1] <= in_chan.level_one;
        end
    end

    vstg_time_div u_time_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .index    (index_use),
        .rate     (rate_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Time in Q.32, modulo 2^48
    assign time_sum = quotient[TIME_W-1:0]
                    + {{8{phase_reg[31]}}, phase_reg, 8'h0}
                    + {origin_reg, 16'h0};
    // Product modulo 2^48, keep the Q0.32 fraction
    assign phase_sum = {prod_lo_reg[47:0]} + {prod_hi_reg, 24'h0};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
            time_reg <= time_sum;
        if (state_reg == ST_MUL)
        begin
            prod_lo_reg <= freq_reg * time_reg[23:0];
            prod_hi_reg <= 24'(freq_reg[23:0] * time_reg[47:24]);
        end
        if (state_reg == ST_PHASE)
            u_reg <= phase_sum[TIME_W-1:16];
    end

    // Lanes
    assign lane_cmd.start = (state_reg == ST_START);
    assign lane_cmd.phase = u_reg;
    assign lane_cmd.ratio = ratio_reg;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        vstg_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (lane_cmd),
            .level  (level_reg[c]),
            .done   (lane_done[c]),
            .sample (lane_sample[c])
        );
        // Zero the channels beyond the active count
        assign merged[c] = ({2'b00, chans_reg} > 4'(c)) ? lane_sample[c] : '0;
    end

    // Sequencer
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_chan.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_chan.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_ADD;
            ST_ADD:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PHASE;
            ST_PHASE: state_next = ST_START;
            ST_START: state_next = ST_LANE;
            ST_LANE:  if (&lane_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_zero_reg <= merged[0];
            out_one_reg  <= merged[1];
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.sample_zero = out_zero_reg;
    assign out_chan.sample_one  = out_one_reg;

endmodule
